// ===== rtl/gmh_pkg.sv =====
// Shared types and constants of the gzip member header parser.
package gmh_pkg;

  // Width of the body byte counter; the counter saturates at its largest value.
  localparam int unsigned COUNT_BITS = 32;

  localparam logic [7:0] MAGIC_ID1     = 8'h1f;
  localparam logic [7:0] MAGIC_ID2     = 8'h8b;
  localparam logic [7:0] METHOD_DEFL   = 8'd8;
  localparam logic [7:0] FLAG_HCRC     = 8'h02;
  localparam logic [7:0] FLAG_EXTRA    = 8'h04;
  localparam logic [7:0] FLAG_NAME     = 8'h08;
  localparam logic [7:0] FLAG_COMMENT  = 8'h10;
  localparam int unsigned FIXED_HDR_LEN = 10;
  localparam int unsigned TRAILER_LEN   = 8;

  typedef enum logic [3:0] {
    ERR_OK         = 4'd0,
    ERR_SHORT      = 4'd1,
    ERR_MAGIC      = 4'd2,
    ERR_METHOD     = 4'd3,
    ERR_XLEN       = 4'd4,
    ERR_EXTRA      = 4'd5,
    ERR_NAME       = 4'd6,
    ERR_COMMENT    = 4'd7,
    ERR_HCRC       = 4'd8,
    ERR_NO_TRAILER = 4'd9
  } err_code_e;

  // One-hot parse phases; the codes grow with the order of the header sections.
  typedef enum logic [9:0] {
    PH_FIXED   = 10'b00_0000_0001,
    PH_XLEN_LO = 10'b00_0000_0010,
    PH_XLEN_HI = 10'b00_0000_0100,
    PH_EXTRA   = 10'b00_0000_1000,
    PH_NAME    = 10'b00_0001_0000,
    PH_COMMENT = 10'b00_0010_0000,
    PH_HCRC0   = 10'b00_0100_0000,
    PH_HCRC1   = 10'b00_1000_0000,
    PH_PAYLOAD = 10'b01_0000_0000,
    PH_DRAIN   = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    err_code_e   error_code;
    logic [31:0] payload_offset;
  } result_t;

endpackage

// ===== rtl/gmh_if.sv =====
// Valid/ready stream interfaces for the body bytes and the header verdicts.
interface gmh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gmh_out_if
  import gmh_pkg::*;
;
  logic        valid;
  logic        ready;
  err_code_e   error_code;
  logic [31:0] payload_offset;

  modport source (output valid, output error_code, output payload_offset, input ready);
  modport sink (input valid, input error_code, input payload_offset, output ready);
endinterface

// ===== rtl/gzip_member_header_parser.sv =====
// Top level of the gzip member header parser: header state machine and verdict buffer.
//
// The parser takes one body byte per cycle and walks the RFC 1952 header: magic bytes,
// deflate method, flag byte, the fixed ten-byte header, then the extra field, name,
// comment and header CRC as the flags ask. Bytes that are not the last of a body give
// no result. The beat that carries the last byte gives one verdict: the offset of the
// deflate payload with code zero, or the first error that applies (a body shorter than
// ten bytes reports the short code ahead of a bad magic or method). When no earlier
// verdict is waiting, it shows on the output in the cycle after the last byte is taken;
// otherwise it waits behind the earlier one. The parser is ready for the next body in
// the very next cycle unless the skid entry filled. A two-entry verdict buffer sits at
// the output, so input beats keep flowing while a verdict waits; input ready drops
// only when both entries are full. The byte counter is COUNT_BITS wide and saturates;
// the reported offset saturates at 32 bits. No memory and no start-up pass are needed.
module gzip_member_header_parser
  import gmh_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  gmh_in_if.sink         in_i,
  gmh_out_if.source      out_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] byte_count_q, byte_count_d;
  logic [7:0]            flags_q, flags_d;
  logic [15:0]           extra_q, extra_d;
  err_code_e             latched_q, latched_d;
  logic [COUNT_BITS-1:0] header_end_q, header_end_d;
  logic [3:0]            trailer_q, trailer_d;

  logic    accept;
  logic    pop;
  logic    push;
  result_t result;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic [63:0] end_ext;

  // First flagged section after the finished one, else the payload.
  function automatic phase_e advance(phase_e done, logic [7:0] flags);
    phase_e nxt;
    if (done < PH_XLEN_LO && (flags & FLAG_EXTRA) != 8'h00) begin
      nxt = PH_XLEN_LO;
    end else if (done < PH_NAME && (flags & FLAG_NAME) != 8'h00) begin
      nxt = PH_NAME;
    end else if (done < PH_COMMENT && (flags & FLAG_COMMENT) != 8'h00) begin
      nxt = PH_COMMENT;
    end else if (done < PH_HCRC0 && (flags & FLAG_HCRC) != 8'h00) begin
      nxt = PH_HCRC0;
    end else begin
      nxt = PH_PAYLOAD;
    end
    return nxt;
  endfunction

  assign accept = in_i.valid & in_i.ready;
  assign pop    = out_valid_q & out_o.ready;
  assign push   = accept & in_i.last_byte;

  always_comb begin
    phase_d      = phase_q;
    byte_count_d = (byte_count_q != CountMax) ? byte_count_q + 1'b1 : byte_count_q;
    flags_d      = flags_q;
    extra_d      = extra_q;
    latched_d    = latched_q;

    case (phase_q)
      PH_FIXED: begin
        if (byte_count_q == COUNT_BITS'(0) && in_i.data_byte != MAGIC_ID1 &&
            latched_d == ERR_OK) begin
          latched_d = ERR_MAGIC;
        end
        if (byte_count_q == COUNT_BITS'(1) && in_i.data_byte != MAGIC_ID2 &&
            latched_d == ERR_OK) begin
          latched_d = ERR_MAGIC;
        end
        if (byte_count_q == COUNT_BITS'(2) && in_i.data_byte != METHOD_DEFL &&
            latched_d == ERR_OK) begin
          latched_d = ERR_METHOD;
        end
        if (byte_count_q == COUNT_BITS'(3)) begin
          flags_d = in_i.data_byte;
        end
        if (byte_count_q >= COUNT_BITS'(FIXED_HDR_LEN - 1)) begin
          phase_d = (latched_d != ERR_OK) ? PH_DRAIN : advance(PH_FIXED, flags_d);
        end
      end
      PH_XLEN_LO: begin
        extra_d = {8'h00, in_i.data_byte};
        phase_d = PH_XLEN_HI;
      end
      PH_XLEN_HI: begin
        extra_d = extra_q | {in_i.data_byte, 8'h00};
        phase_d = (extra_d == 16'h0000) ? advance(PH_EXTRA, flags_q) : PH_EXTRA;
      end
      PH_EXTRA: begin
        extra_d = extra_q - 16'd1;
        if (extra_d == 16'h0000) begin
          phase_d = advance(PH_EXTRA, flags_q);
        end
      end
      PH_NAME, PH_COMMENT: begin
        if (in_i.data_byte == 8'h00) begin
          phase_d = advance(phase_q, flags_q);
        end
      end
      PH_HCRC0: phase_d = PH_HCRC1;
      PH_HCRC1: phase_d = advance(PH_HCRC1, flags_q);
      PH_PAYLOAD: ;
      default: phase_d = PH_DRAIN;
    endcase

    // The trailer count tracks bytes past the header end, up to TRAILER_LEN.
    header_end_d = header_end_q;
    trailer_d    = trailer_q;
    if (phase_q != PH_PAYLOAD && phase_d == PH_PAYLOAD) begin
      header_end_d = byte_count_d;
      trailer_d    = 4'd0;
    end else if (phase_q == PH_PAYLOAD && byte_count_q != CountMax &&
                 trailer_q < 4'(TRAILER_LEN)) begin
      trailer_d = trailer_q + 4'd1;
    end
  end

  assign end_ext = 64'(header_end_d);

  always_comb begin
    result.payload_offset = 32'h0000_0000;
    case (phase_d)
      PH_FIXED:               result.error_code = ERR_SHORT;
      PH_XLEN_LO, PH_XLEN_HI: result.error_code = ERR_XLEN;
      PH_EXTRA:               result.error_code = ERR_EXTRA;
      PH_NAME:                result.error_code = ERR_NAME;
      PH_COMMENT:             result.error_code = ERR_COMMENT;
      PH_HCRC0, PH_HCRC1:     result.error_code = ERR_HCRC;
      PH_PAYLOAD: begin
        if (trailer_d < 4'(TRAILER_LEN)) begin
          result.error_code = ERR_NO_TRAILER;
        end else begin
          result.error_code     = ERR_OK;
          result.payload_offset = (end_ext[63:32] != 32'h0) ? 32'hffff_ffff : end_ext[31:0];
        end
      end
      default:                result.error_code = latched_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_FIXED;
      byte_count_q <= '0;
      flags_q      <= 8'h00;
      extra_q      <= 16'h0000;
      latched_q    <= ERR_OK;
      header_end_q <= '0;
      trailer_q    <= 4'd0;
    end else if (accept) begin
      if (in_i.last_byte) begin
        // The verdict closes the body; the next beat starts a new one.
        phase_q      <= PH_FIXED;
        byte_count_q <= '0;
        flags_q      <= 8'h00;
        extra_q      <= 16'h0000;
        latched_q    <= ERR_OK;
        header_end_q <= '0;
        trailer_q    <= 4'd0;
      end else begin
        phase_q      <= phase_d;
        byte_count_q <= byte_count_d;
        flags_q      <= flags_d;
        extra_q      <= extra_d;
        latched_q    <= latched_d;
        header_end_q <= header_end_d;
        trailer_q    <= trailer_d;
      end
    end
  end

  // Two-entry verdict buffer: the skid entry only fills while the output entry stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (pop) begin
          skid_valid_q <= 1'b0;
        end
      end else if (push) begin
        if (!out_valid_q || pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end
  end

  assign in_i.ready           = ~skid_valid_q;
  assign out_o.valid          = out_valid_q;
  assign out_o.error_code     = out_q.error_code;
  assign out_o.payload_offset = out_q.payload_offset;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a verdict while the output entry is empty");

  a_last_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.last_byte) |=> out_o.valid)
    else $error("last byte accepted but no verdict is presented");

  a_body_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.last_byte) |=>
      (phase_q == PH_FIXED && byte_count_q == '0 && latched_q == ERR_OK))
    else $error("parse state not cleared after the verdict");

  a_error_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.error_code != ERR_OK) |-> out_o.payload_offset == 32'h0)
    else $error("error verdict carries a nonzero payload offset");

  a_drain_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DRAIN |-> (latched_q == ERR_MAGIC || latched_q == ERR_METHOD))
    else $error("drain phase without a latched magic or method error");

endmodule
